[design/sxpd_pkg.sv]
// Shared types and constants for the SysEx patch dump extractor.
// Holds the item structs, the controller/datapath command and status
// groups, and the configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package sxpd_pkg;

  localparam logic [7:0] BYTE_START = 8'hF0;
  localparam logic [7:0] BYTE_END   = 8'hF7;

  localparam int REG_W   = 7;
  localparam int INDEX_W = 5;

  // Configuration register indexes.
  localparam logic CFG_MANUFACTURER_ID = 1'b0;
  localparam logic CFG_DUMP_TYPE       = 1'b1;

  localparam logic [REG_W-1:0] MANUFACTURER_ID_RESET = 7'd65;
  localparam logic [REG_W-1:0] DUMP_TYPE_RESET       = 7'd48;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } sysex_item_t;

  typedef struct packed {
    logic [7:0]         patch_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last_of_patch;
  } patch_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture_type;
    logic clear_count;
    logic store_body;
    logic emit_start;
    logic emit_load;
  } sxpd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic is_id;
    logic eof;
    logic type_match;
    logic count_full;
    logic emit_last;
    logic out_free;
  } sxpd_status_t;

endpackage

[design/sysex_patch_dump_extractor.sv]
// Top level of the SysEx patch dump extractor.
// Joins sxpd_ctrl and sxpd_datapath; uses sxpd_pkg.
//
//   channel   direction  handshake                      payload
//   sysex     in         sysex_valid / sysex_stall      sysex_item_t
//   patch     out        patch_valid / patch_stall      patch_item_t
//   cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// Bytes are taken while sysex_stall is low. The end byte of a matching dump
// starts a burst of PATCH_BYTES output items, one a cycle through the patch
// buffer's single read port; sysex_stall is high for the burst, longer if
// patch_stall holds the output register. Reset is synchronous and restores
// the parser, body count and config registers; the buffer is not cleared.
`timescale 1ns / 1ps

module sysex_patch_dump_extractor #(
  parameter int PATCH_BYTES = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sysex_valid,
  output logic                       sysex_stall,
  input  sxpd_pkg::sysex_item_t      sysex_item,
  output logic                       patch_valid,
  input  logic                       patch_stall,
  output sxpd_pkg::patch_item_t      patch_item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sxpd_pkg::REG_W-1:0] cfg_data
);
  import sxpd_pkg::*;

  sxpd_cmd_t    cmd;
  sxpd_status_t status;

  sxpd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .sysex_valid (sysex_valid),
    .sysex_stall (sysex_stall),
    .status      (status),
    .cmd         (cmd)
  );

  sxpd_datapath #(
    .PATCH_BYTES (PATCH_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sysex_item  (sysex_item),
    .patch_item  (patch_item),
    .patch_valid (patch_valid),
    .patch_stall (patch_stall),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

[design/sxpd_ctrl.sv]
// Parser state machine of the SysEx patch dump extractor.
// Uses sxpd_pkg; drives datapath commands from the datapath status.
`timescale 1ns / 1ps

module sxpd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sysex_valid,
  output logic                  sysex_stall,
  input  sxpd_pkg::sxpd_status_t status,
  output sxpd_pkg::sxpd_cmd_t    cmd
);
  import sxpd_pkg::*;

  typedef enum logic [5:0] {
    ST_SEARCH      = 6'b000001,
    ST_AFTER_START = 6'b000010,
    ST_AFTER_ID    = 6'b000100,
    ST_AFTER_TYPE  = 6'b001000,
    ST_BODY        = 6'b010000,
    ST_EMIT        = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign sysex_stall = (state == ST_EMIT);
  assign accept      = sysex_valid && !sysex_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_SEARCH: begin
        if (accept && status.is_start) state_next = ST_AFTER_START;
      end
      ST_AFTER_START: begin
        if (accept) begin
          // A repeated start byte keeps the parser waiting for the id.
          if (status.is_id) state_next = ST_AFTER_ID;
          else if (status.is_start) state_next = ST_AFTER_START;
          else state_next = ST_SEARCH;
        end
      end
      ST_AFTER_ID: begin
        if (accept) begin
          if (status.is_end) begin
            state_next = ST_SEARCH;
          end else begin
            cmd.capture_type = 1'b1;
            state_next       = ST_AFTER_TYPE;
          end
        end
      end
      ST_AFTER_TYPE: begin
        if (accept) begin
          if (status.is_end) begin
            state_next = ST_SEARCH;
          end else begin
            cmd.clear_count = 1'b1;
            state_next      = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (accept) begin
          if (status.is_end) begin
            if (status.type_match && status.count_full) begin
              cmd.emit_start = 1'b1;
              state_next     = ST_EMIT;
            end else begin
              state_next = ST_SEARCH;
            end
          end else if (!status.count_full) begin
            cmd.store_body = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) state_next = ST_SEARCH;
        end
      end
      default: begin
        state_next = ST_SEARCH;
      end
    endcase
    // End of file abandons an open message, but a dump already closed
    // by this byte is still sent out.
    if (accept && status.eof && state_next != ST_EMIT) state_next = ST_SEARCH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEARCH;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/sxpd_datapath.sv]
// Datapath of the SysEx patch dump extractor: configuration registers,
// byte compares, body count, patch buffer and output register. Uses sxpd_pkg.
`timescale 1ns / 1ps

module sxpd_datapath #(
  parameter int PATCH_BYTES = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [sxpd_pkg::REG_W-1:0] cfg_data,
  input  sxpd_pkg::sysex_item_t  sysex_item,
  output sxpd_pkg::patch_item_t  patch_item,
  output logic                   patch_valid,
  input  logic                   patch_stall,
  input  sxpd_pkg::sxpd_cmd_t    cmd,
  output sxpd_pkg::sxpd_status_t status
);
  import sxpd_pkg::*;

  localparam int CNT_W = $clog2(PATCH_BYTES + 1);
  localparam int IDX_W = (PATCH_BYTES > 1) ? $clog2(PATCH_BYTES) : 1;

  logic [REG_W-1:0] manufacturer_id;
  logic [REG_W-1:0] dump_type;
  logic             type_matches;
  logic [CNT_W-1:0] body_count;
  logic [IDX_W-1:0] emit_idx;
  logic [7:0]       patch_buffer [PATCH_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      manufacturer_id <= MANUFACTURER_ID_RESET;
      dump_type       <= DUMP_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MANUFACTURER_ID: manufacturer_id <= cfg_data;
        CFG_DUMP_TYPE:       dump_type       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Full 8-bit compares: a byte with the top bit set never matches the id or type.
  assign status.is_start   = (sysex_item.data_byte == BYTE_START);
  assign status.is_end     = (sysex_item.data_byte == BYTE_END);
  assign status.is_id      = (sysex_item.data_byte == {1'b0, manufacturer_id});
  assign status.eof        = sysex_item.end_of_file;
  assign status.type_match = type_matches;
  assign status.count_full = (body_count == CNT_W'(PATCH_BYTES));
  assign status.emit_last  = (emit_idx == IDX_W'(PATCH_BYTES - 1));
  assign status.out_free   = !patch_valid || !patch_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_matches <= 1'b0;
      body_count   <= '0;
    end else begin
      if (cmd.capture_type) type_matches <= (sysex_item.data_byte == {1'b0, dump_type});
      if (cmd.clear_count) body_count <= '0;
      else if (cmd.store_body) body_count <= body_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_body) patch_buffer[body_count[IDX_W-1:0]] <= sysex_item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx    <= '0;
      patch_valid <= 1'b0;
    end else begin
      if (cmd.emit_start) emit_idx <= '0;
      else if (cmd.emit_load) emit_idx <= emit_idx + IDX_W'(1);
      if (cmd.emit_load) patch_valid <= 1'b1;
      else if (!patch_stall) patch_valid <= 1'b0;
    end
  end

  // The buffer read is registered straight into the output item.
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      patch_item.patch_byte    <= patch_buffer[emit_idx];
      patch_item.byte_index    <= INDEX_W'(emit_idx);
      patch_item.last_of_patch <= status.emit_last;
    end
  end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the SysEx patch dump extractor.
// Drives a byte stream of dumps and broken messages through sysex_patch_dump_extractor
// and checks every patch byte against its own deframer model; uses sxpd_pkg.
`timescale 1ns / 1ps

module testbench;
  import sxpd_pkg::*;

  localparam int PATCH_BYTES  = 18;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;

  typedef enum logic [2:0] {
    SEEK_START,
    GOT_START,
    GOT_ID,
    GOT_TYPE,
    IN_BODY
  } dump_phase_t;

  typedef enum int {
    MSG_GOOD,
    MSG_SHORT,
    MSG_WRONG_TYPE,
    MSG_WRONG_ID,
    MSG_END_EARLY,
    MSG_EOF_ABORT,
    MSG_NOISE
  } msg_kind_t;

  logic clk;
  logic rst = 1'b1;
  logic sysex_valid = 1'b0;
  logic sysex_stall;
  sysex_item_t sysex_item = '0;
  logic patch_valid;
  logic patch_stall = 1'b0;
  patch_item_t patch_item;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [REG_W-1:0] cfg_data = '0;

  // Deframer model state and its copy of the configuration.
  dump_phase_t dump_phase = SEEK_START;
  logic dump_type_hit = 1'b0;
  int body_len = 0;
  logic [7:0] body_store [PATCH_BYTES];
  logic [REG_W-1:0] mfr_id_cfg = MANUFACTURER_ID_RESET;
  logic [REG_W-1:0] dump_type_cfg = DUMP_TYPE_RESET;

  sysex_item_t pending_bytes[$];
  patch_item_t expected_patch[$];

  logic sysex_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic long_hold_req = 1'b0;
  int hold_left = 0;
  int queued_n = 0;
  int bytes_taken = 0;
  int patch_bytes_checked = 0;
  int dumps_seen = 0;
  int error_count = 0;

  sysex_patch_dump_extractor #(
    .PATCH_BYTES(PATCH_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .sysex_valid(sysex_valid),
    .sysex_stall(sysex_stall),
    .sysex_item (sysex_item),
    .patch_valid(patch_valid),
    .patch_stall(patch_stall),
    .patch_item (patch_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 50) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Advances the deframer by one stream byte and queues any patch it completes.
  task automatic deframe_byte(input sysex_item_t it);
    patch_item_t res;
    int k;
    case (dump_phase)
      SEEK_START: begin
        if (it.data_byte == BYTE_START) dump_phase = GOT_START;
      end
      GOT_START: begin
        if (it.data_byte == {1'b0, mfr_id_cfg}) dump_phase = GOT_ID;
        else if (it.data_byte == BYTE_START) dump_phase = GOT_START;
        else dump_phase = SEEK_START;
      end
      GOT_ID: begin
        if (it.data_byte == BYTE_END) begin
          dump_phase = SEEK_START;
        end else begin
          // The whole byte is compared, so types with the top bit set never match.
          dump_type_hit = (it.data_byte == {1'b0, dump_type_cfg});
          dump_phase = GOT_TYPE;
        end
      end
      GOT_TYPE: begin
        if (it.data_byte == BYTE_END) begin
          dump_phase = SEEK_START;
        end else begin
          body_len = 0;
          dump_phase = IN_BODY;
        end
      end
      IN_BODY: begin
        if (it.data_byte == BYTE_END) begin
          if (dump_type_hit && body_len >= PATCH_BYTES) begin
            for (k = 0; k < PATCH_BYTES; k++) begin
              res.patch_byte = body_store[k];
              res.byte_index = k[INDEX_W-1:0];
              res.last_of_patch = (k == PATCH_BYTES - 1);
              expected_patch.insert(expected_patch.size(), res);
            end
          end
          dump_phase = SEEK_START;
        end else if (body_len < PATCH_BYTES) begin
          body_store[body_len] = it.data_byte;
          body_len++;
        end
      end
      default: begin
        dump_phase = SEEK_START;
      end
    endcase
    if (it.end_of_file) dump_phase = SEEK_START;
  endtask

  // Sender: offers the next pending item, holding it while the block stalls.
  always @(negedge clk) begin
    if (!sysex_valid || sysex_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sysex_item <= pending_bytes.pop_front();
        sysex_valid <= 1'b1;
      end else begin
        sysex_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      patch_stall <= 1'b1;
    end else begin
      patch_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: feeds accepted stream bytes to the model and checks patch items.
  always @(posedge clk) begin
    patch_item_t want;
    if (rst) begin
      sysex_taken = 1'b0;
    end else begin
      sysex_taken = sysex_valid && !sysex_stall;
      if (sysex_taken) begin
        bytes_taken++;
        deframe_byte(sysex_item);
      end
      if (patch_valid && !patch_stall) begin
        if (expected_patch.size() == 0) begin
          report_mismatch($sformatf("unexpected patch item byte=%02h index=%0d last=%0b",
                                    patch_item.patch_byte, patch_item.byte_index,
                                    patch_item.last_of_patch));
        end else begin
          want = expected_patch.pop_front();
          patch_bytes_checked++;
          if (want.last_of_patch) dumps_seen++;
          if (patch_item.patch_byte !== want.patch_byte)
            report_mismatch($sformatf("patch_byte %02h, expected %02h (index %0d)",
                                      patch_item.patch_byte, want.patch_byte,
                                      want.byte_index));
          if (patch_item.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, expected %0d",
                                      patch_item.byte_index, want.byte_index));
          if (patch_item.last_of_patch !== want.last_of_patch)
            report_mismatch($sformatf("last_of_patch %0b, expected %0b (index %0d)",
                                      patch_item.last_of_patch, want.last_of_patch,
                                      want.byte_index));
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic eof);
    sysex_item_t it;
    it.data_byte = b;
    it.end_of_file = eof;
    pending_bytes.insert(pending_bytes.size(), it);
    queued_n++;
  endtask

  function automatic logic [7:0] non_end_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == BYTE_END);
    return b;
  endfunction

  function automatic msg_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return MSG_GOOD;
    if (r < 60) return MSG_SHORT;
    if (r < 70) return MSG_WRONG_TYPE;
    if (r < 77) return MSG_WRONG_ID;
    if (r < 84) return MSG_END_EARLY;
    if (r < 92) return MSG_EOF_ABORT;
    return MSG_NOISE;
  endfunction

  // Builds one message of the given kind for the current configuration.
  task automatic queue_message(input msg_kind_t kind);
    logic [7:0] msg[$];
    logic [7:0] id_b;
    logic [7:0] type_b;
    int n_body;
    int eof_at;
    int i;
    int r;
    id_b = {1'b0, mfr_id_cfg};
    type_b = {1'b0, dump_type_cfg};
    eof_at = -1;
    r = $urandom_range(99);
    if (r < 70) n_body = PATCH_BYTES;
    else if (r < 95) n_body = $urandom_range(PATCH_BYTES + 6, PATCH_BYTES + 1);
    else n_body = 40;
    case (kind)
      MSG_SHORT: begin
        n_body = $urandom_range(PATCH_BYTES - 1, 0);
      end
      MSG_WRONG_TYPE: begin
        if ($urandom_range(1) == 0) type_b = type_b | 8'h80;
        else type_b = non_end_byte();
      end
      MSG_WRONG_ID: begin
        do begin
          id_b = 8'($urandom_range(255));
        end while (id_b == {1'b0, mfr_id_cfg});
      end
      MSG_NOISE: begin
        n_body = $urandom_range(3, 1);
        for (i = 0; i < n_body; i++) begin
          queue_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
        return;
      end
      default: begin
      end
    endcase
    // A repeated start byte in front still opens the message.
    if (kind == MSG_GOOD && $urandom_range(4) == 0) msg.insert(msg.size(), BYTE_START);
    msg.insert(msg.size(), BYTE_START);
    msg.insert(msg.size(), id_b);
    if (kind == MSG_END_EARLY) begin
      if ($urandom_range(1) == 0) msg.insert(msg.size(), type_b);
    end else begin
      msg.insert(msg.size(), type_b);
      msg.insert(msg.size(), non_end_byte());
      for (i = 0; i < n_body; i++) msg.insert(msg.size(), non_end_byte());
    end
    msg.insert(msg.size(), BYTE_END);
    if (kind == MSG_EOF_ABORT) begin
      eof_at = $urandom_range(msg.size() - 2, 0);
      msg = msg[0:eof_at];
    end else if (kind == MSG_GOOD && $urandom_range(5) == 0) begin
      eof_at = msg.size() - 1;
    end
    for (i = 0; i < msg.size(); i++) queue_byte(msg[i], i == eof_at);
  endtask

  task automatic run_phase(input int budget);
    int start_n;
    start_n = queued_n;
    queue_message(MSG_GOOD);
    while (queued_n - start_n < budget) queue_message(pick_kind());
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_bytes.size() != 0 || sysex_valid || expected_patch.size() != 0)
      @(posedge clk);
    // Lets a burst from a dump that raised no expectation run out.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MANUFACTURER_ID) mfr_id_cfg = value;
    else dump_type_cfg = value;
  endtask

  initial begin
    int i;
    send_idle_pct = 6;
    recv_idle_pct = 52;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset configuration.
    queue_byte(BYTE_END, 1'b0);               // end byte while searching
    queue_byte(BYTE_START, 1'b0);             // wrong manufacturer
    queue_byte(8'h42, 1'b0);
    queue_byte(BYTE_START, 1'b0);             // double start, end byte as type
    queue_byte(BYTE_START, 1'b0);
    queue_byte({1'b0, MANUFACTURER_ID_RESET}, 1'b0);
    queue_byte(BYTE_END, 1'b0);
    queue_byte(BYTE_START, 1'b0);             // end byte as channel
    queue_byte({1'b0, MANUFACTURER_ID_RESET}, 1'b0);
    queue_byte({1'b0, DUMP_TYPE_RESET}, 1'b0);
    queue_byte(BYTE_END, 1'b0);
    // A full dump with extreme body bytes, closed by the final byte of the file.
    queue_byte(BYTE_START, 1'b0);
    queue_byte({1'b0, MANUFACTURER_ID_RESET}, 1'b0);
    queue_byte({1'b0, DUMP_TYPE_RESET}, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(BYTE_START, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h80, 1'b0);
    for (i = 5; i < PATCH_BYTES; i++) queue_byte(non_end_byte(), 1'b0);
    queue_byte(BYTE_END, 1'b1);

    run_phase(80);
    wait_drained();

    write_cfg(CFG_MANUFACTURER_ID, '0);
    write_cfg(CFG_DUMP_TYPE, '1);
    send_idle_pct = 52;
    recv_idle_pct = 6;
    run_phase(85);
    wait_drained();

    write_cfg(CFG_MANUFACTURER_ID, '1);
    write_cfg(CFG_DUMP_TYPE, '0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    run_phase(85);
    wait_drained();

    write_cfg(CFG_MANUFACTURER_ID, REG_W'($urandom_range(127)));
    write_cfg(CFG_DUMP_TYPE, REG_W'($urandom_range(127)));
    run_phase(85);
    wait_drained();

    $display("Run covered %0d stream bytes over four register settings and three idling modes,",
             bytes_taken);
    $display("with %0d dumps extracted and %0d patch bytes checked.",
             dumps_seen, patch_bytes_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: stream or patch output stopped making progress.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
